@@ rtl/core/keypad_alarm_panel_fsm_assert.svh @@
// Assertion macros for the keypad alarm panel checker.
// No dependencies; included by the checker file.
`ifndef KEYPAD_ALARM_PANEL_FSM_ASSERT_SVH
`define KEYPAD_ALARM_PANEL_FSM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define KAP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad alarm panel: assertion failed");

// next-cycle implication, disabled during reset
`define KAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad alarm panel: assertion failed");

// next-cycle implication, always checked
`define KAP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("keypad alarm panel: assertion failed");

`endif

@@ rtl/core/kap_pkg.sv @@
// Shared constants for the keypad alarm panel: widths, key codes, message codes,
// lamp patterns and register indexes. No dependencies.
package kap_pkg;

    localparam int LIGHT_BITS_DEF = 10;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int KEY_W          = 5;
    localparam int BTN_W          = 4;
    localparam int LAMP_W         = 8;
    localparam int MSG_W          = 3;
    localparam int STARS_W        = 2;
    localparam int WAIT_W         = 16;
    localparam int OUT_W          = 16;

    // output tdata field positions
    localparam int OUT_MSG_LSB    = LAMP_W;
    localparam int OUT_STARS_LSB  = LAMP_W + MSG_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd5;

    // register reset values
    localparam logic [KEY_W-1:0]  CODE_FIRST_RST  = 5'd1;
    localparam logic [KEY_W-1:0]  CODE_SECOND_RST = 5'd2;
    localparam logic [KEY_W-1:0]  CODE_THIRD_RST  = 5'd3;
    localparam int                LIGHT_MAX_RST   = 'h0AA;
    localparam int                LIGHT_MIN_RST   = 'h01F;
    localparam logic [WAIT_W-1:0] TIMEOUT_RST     = 16'd10000;

    // key codes
    localparam logic [KEY_W-1:0] KEY_NONE = 5'd0;
    localparam logic [KEY_W-1:0] KEY_ZERO = 5'd10;
    localparam logic [KEY_W-1:0] KEY_STAR = 5'd11;
    localparam logic [KEY_W-1:0] KEY_HASH = 5'd12;

    // button patterns in potential intruder and intruder
    localparam logic [BTN_W-1:0] BTN_NONE      = 4'd0;
    localparam logic [BTN_W-1:0] BTN_DISTRESS1 = 4'd2;
    localparam logic [BTN_W-1:0] BTN_DISTRESS2 = 4'd4;
    localparam logic [BTN_W-1:0] BTN_RESET     = 4'd9;

    // message codes
    localparam logic [MSG_W-1:0] MSG_DISARMED = 3'd0;
    localparam logic [MSG_W-1:0] MSG_AWAY     = 3'd1;
    localparam logic [MSG_W-1:0] MSG_STAY     = 3'd2;
    localparam logic [MSG_W-1:0] MSG_POTINT   = 3'd3;
    localparam logic [MSG_W-1:0] MSG_INTRUDER = 3'd4;
    localparam logic [MSG_W-1:0] MSG_SYSRESET = 3'd5;

    // lamp patterns
    localparam logic [LAMP_W-1:0] LAMP_RST      = 8'h01;
    localparam logic [LAMP_W-1:0] LAMP_OFF      = 8'h00;
    localparam logic [LAMP_W-1:0] LAMP_BAND0    = 8'h42;
    localparam logic [LAMP_W-1:0] LAMP_BAND1    = 8'h26;
    localparam logic [LAMP_W-1:0] LAMP_BAND2    = 8'h0E;
    localparam logic [LAMP_W-1:0] LAMP_BAND3    = 8'h1E;
    localparam logic [LAMP_W-1:0] LAMP_SIREN_HI = 8'hE0;
    localparam logic [LAMP_W-1:0] LAMP_SIREN_LO = 8'h60;
    localparam logic [LAMP_W-1:0] LAMP_SYSRESET = 8'h12;
    localparam logic [LAMP_W-1:0] LAMP_DISTRESS = 8'h10;

endpackage

@@ rtl/core/keypad_alarm_panel_fsm.sv @@
// Keypad alarm panel mode controller, one tick request in, one result out.
// Depends on kap_pkg.
//
//  channel   dir  handshake              payload
//  s (tick)  in   i_s_tvalid/o_s_tready  i_s_tdata: key, sensor, buttons, light level
//  m (state) out  o_m_tvalid/i_m_tready  o_m_tdata: lamp port, message, stars shown
//  cfg       in   i_cfg_wr_en            i_cfg_idx, i_cfg_wdata
//
//  One request per cycle while the result is not stalled; each request passes the input
//  register, then mode logic into the result register.
//  A stalled result holds the pipe: the input register still takes one request.
//  Synchronous active-low reset clears the valid flags and sets mode state and configuration
module keypad_alarm_panel_fsm
    import kap_pkg::*;
#(
    parameter int LIGHT_BITS = LIGHT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // key[4:0], sensor_tripped[5], buttons[9:6], light_level[10 +: LIGHT_BITS], zero pad
    input  logic [((10+LIGHT_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // lamp_port[7:0], message[10:8], stars_shown[12:11], zero pad
    output logic [OUT_W-1:0]     o_m_tdata,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int LIGHT_LSB = KEY_W + 1 + BTN_W;

    typedef enum logic [7:0] {
        MODE_START    = 8'b0000_0001,
        MODE_DISARM   = 8'b0000_0010,
        MODE_AWAY     = 8'b0000_0100,
        MODE_STAY     = 8'b0000_1000,
        MODE_POTINT   = 8'b0001_0000,
        MODE_INTRUDER = 8'b0010_0000,
        MODE_RESET    = 8'b0100_0000,
        MODE_DISTRESS = 8'b1000_0000
    } t_mode;

    function automatic logic [MSG_W-1:0] base_msg(input t_mode m);
        logic [MSG_W-1:0] r;
        unique case (m)
            MODE_AWAY:     r = MSG_AWAY;
            MODE_STAY:     r = MSG_STAY;
            MODE_POTINT:   r = MSG_POTINT;
            MODE_INTRUDER: r = MSG_INTRUDER;
            MODE_RESET:    r = MSG_SYSRESET;
            default:       r = MSG_DISARMED;
        endcase
        return r;
    endfunction

    // configuration
    logic [KEY_W-1:0]      r_code_first, r_code_second, r_code_third;
    logic [LIGHT_BITS-1:0] r_light_max, r_light_min;
    logic [WAIT_W-1:0]     r_timeout;

    // input register
    logic                  r_in_vld;
    logic [KEY_W-1:0]      r_key;
    logic                  r_sensor;
    logic [BTN_W-1:0]      r_btn;
    logic [LIGHT_BITS-1:0] r_light;

    // mode state
    t_mode                 r_mode, n_mode;
    logic [2:0]            r_entry, n_entry;
    logic [KEY_W-1:0]      r_prev_key, n_prev_key;
    logic [LAMP_W-1:0]     r_lamp, n_lamp;
    logic                  r_siren, n_siren;
    logic [WAIT_W-1:0]     r_wait, n_wait;
    logic [MSG_W-1:0]      r_msg, n_msg;

    // result register
    logic                  r_out_vld;
    logic [OUT_W-1:0]      r_out_data;

    logic                  s_fire, adv;
    logic [KEY_W-1:0]      x, digit_odd, digit_even;
    logic [WAIT_W:0]       wait_inc;
    logic [LIGHT_BITS-1:0] band_step;
    logic [LIGHT_BITS+1:0] thr1, thr2, thr3, level_ext;
    logic [LAMP_W-1:0]     band_lamp;
    logic [3:0]            star_sum;
    logic [STARS_W-1:0]    stars;

    assign adv        = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || adv;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_first  <= CODE_FIRST_RST;
            r_code_second <= CODE_SECOND_RST;
            r_code_third  <= CODE_THIRD_RST;
            r_light_max   <= LIGHT_BITS'(LIGHT_MAX_RST);
            r_light_min   <= LIGHT_BITS'(LIGHT_MIN_RST);
            r_timeout     <= TIMEOUT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_CODE_FIRST:  r_code_first  <= i_cfg_wdata[KEY_W-1:0];
                CFG_CODE_SECOND: r_code_second <= i_cfg_wdata[KEY_W-1:0];
                CFG_CODE_THIRD:  r_code_third  <= i_cfg_wdata[KEY_W-1:0];
                CFG_LIGHT_MAX:   r_light_max   <= i_cfg_wdata[LIGHT_BITS-1:0];
                CFG_LIGHT_MIN:   r_light_min   <= i_cfg_wdata[LIGHT_BITS-1:0];
                CFG_TIMEOUT:     r_timeout     <= i_cfg_wdata[WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_fire) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_key    <= i_s_tdata[KEY_W-1:0];
            r_sensor <= i_s_tdata[KEY_W];
            r_btn    <= i_s_tdata[KEY_W+1 +: BTN_W];
            r_light  <= i_s_tdata[LIGHT_LSB +: LIGHT_BITS];
        end
    end

    // light bands for away mode
    always_comb begin
        band_step = (r_light_max >= r_light_min) ? ((r_light_max - r_light_min) >> 2)
                                                 : '0;
        thr1      = {2'b00, band_step} + {2'b00, r_light_min};
        thr2      = {1'b0, band_step, 1'b0} + {2'b00, r_light_min};
        thr3      = {1'b0, band_step, 1'b0} + {2'b00, band_step} + {2'b00, r_light_min};
        level_ext = {2'b00, r_light};
        priority if (level_ext <= thr1) begin
            band_lamp = LAMP_BAND0;
        end else if (level_ext <= thr2) begin
            band_lamp = LAMP_BAND1;
        end else if (level_ext <= thr3) begin
            band_lamp = LAMP_BAND2;
        end else begin
            band_lamp = LAMP_BAND3;
        end
    end

    always_comb begin
        x          = r_prev_key;
        n_mode     = r_mode;
        n_entry    = r_entry;
        n_lamp     = r_lamp;
        n_siren    = r_siren;
        n_wait     = r_wait;
        n_msg      = r_msg;
        wait_inc   = {1'b0, r_wait} + 17'd1;
        digit_odd  = (r_entry == 3'd1) ? r_code_first :
                     (r_entry == 3'd3) ? r_code_second : r_code_third;
        digit_even = (r_entry == 3'd2) ? r_code_second : r_code_third;

        unique case (r_mode)
            MODE_START: begin
                n_mode  = MODE_DISARM;
                n_entry = 3'd0;
                n_msg   = MSG_DISARMED;
            end
            MODE_POTINT: begin
                n_wait = wait_inc[WAIT_W-1:0];
                if (wait_inc < {1'b0, r_timeout}) begin
                    if (r_btn != BTN_NONE) begin
                        n_wait  = '0;
                        n_entry = 3'd0;
                        if (r_btn == BTN_DISTRESS1 || r_btn == BTN_DISTRESS2) begin
                            n_lamp = LAMP_DISTRESS;
                            n_mode = MODE_DISTRESS;
                            n_msg  = MSG_DISARMED;
                        end else if (r_btn == BTN_RESET) begin
                            n_lamp = LAMP_SYSRESET;
                            n_mode = MODE_RESET;
                            n_msg  = MSG_SYSRESET;
                        end else begin
                            n_mode = MODE_INTRUDER;
                            n_msg  = MSG_INTRUDER;
                        end
                    end
                end else begin
                    n_wait  = '0;
                    n_mode  = MODE_INTRUDER;
                    n_entry = 3'd0;
                    n_msg   = MSG_INTRUDER;
                end
            end
            MODE_INTRUDER: begin
                n_siren = ~r_siren;
                n_lamp  = n_siren ? LAMP_SIREN_HI : LAMP_SIREN_LO;
                if (r_btn == BTN_RESET) begin
                    n_lamp  = LAMP_SYSRESET;
                    n_mode  = MODE_RESET;
                    n_entry = 3'd0;
                    n_msg   = MSG_SYSRESET;
                end
            end
            MODE_DISARM, MODE_AWAY, MODE_STAY, MODE_RESET, MODE_DISTRESS: begin
                if (r_entry != 3'd0) begin
                    // code entry: odd steps hold a digit until release, even steps wait for the next digit
                    unique case (r_entry)
                        3'd1, 3'd3, 3'd5: begin
                            if (x == digit_odd) begin
                                n_entry = r_entry;
                            end else if (x == KEY_NONE) begin
                                n_entry = r_entry + 3'd1;
                            end else begin
                                n_entry = 3'd0;
                                n_msg   = base_msg(r_mode);
                            end
                        end
                        3'd2, 3'd4: begin
                            if (x == KEY_NONE) begin
                                n_entry = r_entry;
                            end else if (x == digit_even) begin
                                n_entry = r_entry + 3'd1;
                            end else begin
                                n_entry = 3'd0;
                                n_msg   = base_msg(r_mode);
                            end
                        end
                        3'd6: begin
                            if (x == KEY_NONE) begin
                                n_entry = r_entry;
                            end else if (r_mode == MODE_DISARM && x == KEY_HASH) begin
                                n_mode  = MODE_AWAY;
                                n_entry = 3'd0;
                                n_msg   = MSG_AWAY;
                            end else if (r_mode == MODE_DISARM && x == KEY_STAR) begin
                                n_mode  = MODE_STAY;
                                n_entry = 3'd0;
                                n_msg   = MSG_STAY;
                            end else if (r_mode != MODE_DISARM && x == KEY_ZERO) begin
                                if (r_mode != MODE_STAY) begin
                                    n_lamp = LAMP_OFF;
                                end
                                n_mode  = MODE_DISARM;
                                n_entry = 3'd0;
                                n_msg   = MSG_DISARMED;
                            end else begin
                                n_entry = 3'd0;
                                n_msg   = base_msg(r_mode);
                            end
                        end
                        default: begin
                            n_entry = 3'd0;
                            n_msg   = base_msg(r_mode);
                        end
                    endcase
                end else if (r_mode == MODE_AWAY) begin
                    if (x != r_code_first) begin
                        if (r_sensor) begin
                            n_lamp  = LAMP_OFF;
                            n_mode  = MODE_POTINT;
                            n_entry = 3'd0;
                            n_msg   = MSG_POTINT;
                        end else begin
                            n_lamp = band_lamp;
                        end
                    end else begin
                        n_entry = 3'd1;
                    end
                end else if (r_mode == MODE_STAY && r_sensor) begin
                    n_mode  = MODE_INTRUDER;
                    n_entry = 3'd0;
                    n_msg   = MSG_INTRUDER;
                end else if (x == r_code_first) begin
                    n_entry = 3'd1;
                end
            end
            default: begin
                n_mode  = MODE_START;
                n_entry = 3'd0;
                n_msg   = MSG_DISARMED;
            end
        endcase

        star_sum = {1'b0, r_entry} + 4'd1;
        if (n_entry == 3'd0) begin
            stars = '0;
        end else if (star_sum[3]) begin
            stars = 2'd3;
        end else begin
            stars = star_sum[2:1];
        end

        if (n_mode != MODE_POTINT && n_mode != MODE_INTRUDER && n_mode != MODE_START) begin
            n_prev_key = r_key;
        end else begin
            n_prev_key = r_prev_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_START;
            r_entry    <= 3'd0;
            r_prev_key <= KEY_NONE;
            r_lamp     <= LAMP_RST;
            r_siren    <= 1'b0;
            r_wait     <= '0;
            r_msg      <= MSG_DISARMED;
        end else if (adv) begin
            r_mode     <= n_mode;
            r_entry    <= n_entry;
            r_prev_key <= n_prev_key;
            r_lamp     <= n_lamp;
            r_siren    <= n_siren;
            r_wait     <= n_wait;
            r_msg      <= n_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {{(OUT_W-LAMP_W-MSG_W-STARS_W){1'b0}}, stars, n_msg, n_lamp};
        end
    end

endmodule

@@ rtl/core/kap_checker.sv @@
// Port-level checker for the keypad alarm panel, bound to the top level.
// Depends on kap_pkg and keypad_alarm_panel_fsm_assert.svh.
`include "keypad_alarm_panel_fsm_assert.svh"

module kap_checker
    import kap_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] i_m_tdata
);

    logic [MSG_W-1:0]   msg;
    logic [STARS_W-1:0] stars;
    logic               siren;
    logic               alarm_msg;

    assign msg       = i_m_tdata[OUT_MSG_LSB +: MSG_W];
    assign stars     = i_m_tdata[OUT_STARS_LSB +: STARS_W];
    assign siren     = i_m_tdata[LAMP_W-1];
    assign alarm_msg = (msg == MSG_POTINT) || (msg == MSG_INTRUDER);

    `KAP_ASSERT_NEXT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n, !i_m_tvalid)
    `KAP_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid)
    `KAP_ASSERT_NOW(a_msg_legal, i_clk, i_rst_n, i_m_tvalid, msg <= MSG_SYSRESET)
    `KAP_ASSERT_NOW(a_no_stars_alarm, i_clk, i_rst_n, i_m_tvalid && stars != '0, !alarm_msg)
    `KAP_ASSERT_NOW(a_siren_intruder, i_clk, i_rst_n, i_m_tvalid && siren, msg == MSG_INTRUDER)

endmodule

bind keypad_alarm_panel_fsm kap_checker u_kap_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
